FILE: hw/rtl/spi_pkg.sv
// Shared types, constants and state encodings for the speed profile interpolator.
package spi_pkg;

   localparam int unsigned MaxPointsDefault = 256;
   localparam int unsigned DataW            = 32;
   localparam int unsigned CountW           = 9;
   localparam int unsigned FieldCount       = 5;

   // Field slots of one stored point.
   localparam logic [2:0] FieldPos   = 3'd0;
   localparam logic [2:0] FieldTime  = 3'd1;
   localparam logic [2:0] FieldSpeed = 3'd2;
   localparam logic [2:0] FieldAccel = 3'd3;
   localparam logic [2:0] FieldJerk  = 3'd4;

   typedef enum logic [1:0] {
      OP_APPEND    = 2'd0,
      OP_EVAL_TIME = 2'd1,
      OP_EVAL_POS  = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOO_FEW    = 3'd1,
      ST_OUT_RANGE  = 3'd2,
      ST_NOT_LATER  = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] position;
      logic signed [31:0] time_req;
      logic signed [31:0] speed;
      logic signed [31:0] accel;
      logic signed [31:0] jerk;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] out_position;
      logic signed [31:0] out_time;
      logic signed [31:0] out_speed;
      logic signed [31:0] out_accel;
      logic signed [31:0] out_jerk;
      logic signed [31:0] total_duration;
      logic signed [31:0] total_distance;
      logic [8:0]         point_count;
   } rsp_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_SEARCH,
      SEQ_COMPARE,
      SEQ_FOUND,
      SEQ_POINT,
      SEQ_LOAD0,
      SEQ_LOAD1,
      SEQ_MSTART,
      SEQ_MWAIT,
      SEQ_RESPOND
   } seq_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_DONE
   } md_state_type;

   // Command to the shared multiply-divide unit.
   typedef struct packed {
      logic        start;
      logic [31:0] mag;
      logic [31:0] num;
      logic [31:0] den;
   } md_cmd_type;

endpackage

FILE: hw/rtl/speed_profile_interpolator_unit.sv
// Top level of the speed profile interpolator: sequencer, point stores and result path.
//
//  channel | ports                    | transfer
//  --------+--------------------------+-------------------------------------------
//  input   | start, busy, req_data    | start high and busy low at a rising edge
//  result  | rsp_strobe, rsp_data     | one cycle with rsp_strobe high, no stall
//
// An append, a rejection or a no-operation passes from decode straight to respond. An
// evaluation adds a search and a compare state per search step (nine at most for a full
// table) and the found state; at a table edge it returns the stored point, else fetches
// the bracketing points and runs four interpolations on the shared multiply-divide unit. Busy
// stays high until the result cycle has ended. Synchronous reset empties the table without
// a clearing pass, as stale entries are never read. The receiver cannot stall the result.
module speed_profile_interpolator_unit #(
   parameter int unsigned MAX_POINTS = spi_pkg::MaxPointsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spi_pkg::req_type req_data,
   output logic             rsp_strobe,
   output spi_pkg::rsp_type rsp_data
);

   localparam int unsigned IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int unsigned CntW = $clog2(MAX_POINTS + 1);

   spi_pkg::seq_state_type state_ff, state_in;
   spi_pkg::req_type       req_ff, req_in;
   spi_pkg::status_type    status_ff, status_in;
   logic                   by_time_ff, by_time_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic [CntW-1:0]        lo_ff, lo_in;
   logic [CntW-1:0]        span_ff, span_in;
   logic [CntW-1:0]        mid_ff, mid_in;
   logic [1:0]             fld_ff, fld_in;
   logic signed [31:0]     first_time_ff, first_time_in;
   logic signed [31:0]     first_pos_ff, first_pos_in;
   logic signed [31:0]     last_time_ff, last_time_in;
   logic signed [31:0]     last_pos_ff, last_pos_in;
   logic signed [31:0]     x0_ff [spi_pkg::FieldCount];
   logic signed [31:0]     x0_in [spi_pkg::FieldCount];
   logic signed [31:0]     x1_ff [spi_pkg::FieldCount];
   logic signed [31:0]     x1_in [spi_pkg::FieldCount];
   logic signed [31:0]     v_ff  [spi_pkg::FieldCount];
   logic signed [31:0]     v_in  [spi_pkg::FieldCount];

   // Store ports: all five stores share one write and one read address.
   logic                   wr_en;
   logic [IdxW-1:0]        wr_addr;
   logic [IdxW-1:0]        rd_addr;
   logic [31:0]            wr_word [spi_pkg::FieldCount];
   logic [31:0]            rd_word [spi_pkg::FieldCount];

   spi_pkg::md_cmd_type    md_cmd;
   logic                   md_done;
   logic [31:0]            md_quo;

   // Decisions taken on the latched transaction.
   spi_pkg::op_type        op;
   logic signed [31:0]     key;
   logic signed [31:0]     key_rd;
   logic signed [31:0]     first_key;
   logic signed [31:0]     last_key;
   logic                   is_full;
   logic                   not_later;
   logic                   too_few;
   logic                   out_range;
   logic                   eval_go;
   logic                   at_edge;
   logic [CntW-1:0]        half;
   logic [2:0]             tgt;
   logic [2:0]             kfld;
   logic signed [32:0]     dx;
   logic signed [32:0]     dk;
   logic signed [32:0]     dn;
   logic                   den_pos;
   logic signed [31:0]     interp;

   genvar g;
   generate
      for (g = 0; g < spi_pkg::FieldCount; g++) begin : g_store
         spi_ram #(
            .WIDTH(spi_pkg::DataW),
            .DEPTH(MAX_POINTS)
         ) u_store (
            .clock  (clock),
            .wr_en  (wr_en),
            .wr_addr(wr_addr),
            .wr_data(wr_word[g]),
            .rd_addr(rd_addr),
            .rd_data(rd_word[g])
         );
      end
   endgenerate

   assign wr_word[spi_pkg::FieldPos]   = req_ff.position;
   assign wr_word[spi_pkg::FieldTime]  = req_ff.time_req;
   assign wr_word[spi_pkg::FieldSpeed] = req_ff.speed;
   assign wr_word[spi_pkg::FieldAccel] = req_ff.accel;
   assign wr_word[spi_pkg::FieldJerk]  = req_ff.jerk;
   assign wr_addr = count_ff[IdxW-1:0];

   spi_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .cmd     (md_cmd),
      .done    (md_done),
      .quotient(md_quo)
   );

   always_comb begin
      op        = spi_pkg::op_type'(req_ff.operation);
      key       = by_time_ff ? req_ff.time_req : req_ff.position;
      kfld      = by_time_ff ? spi_pkg::FieldTime : spi_pkg::FieldPos;
      key_rd    = by_time_ff ? rd_word[spi_pkg::FieldTime] : rd_word[spi_pkg::FieldPos];
      first_key = by_time_ff ? first_time_ff : first_pos_ff;
      last_key  = by_time_ff ? last_time_ff : last_pos_ff;
      is_full   = (count_ff >= CntW'(MAX_POINTS));
      not_later = (count_ff != '0) && !(last_time_ff < req_ff.time_req);
      too_few   = (count_ff < CntW'(2));
      out_range = (key < first_key) || (key > last_key);
      eval_go   = ((op == spi_pkg::OP_EVAL_TIME) || (op == spi_pkg::OP_EVAL_POS))
                  && !too_few && !out_range;
      at_edge   = (lo_ff >= count_ff) || (lo_ff == '0);
      half      = span_ff >> 1;
      // The first interpolated field is the one that is not the key.
      if (fld_ff == 2'd0) begin
         tgt = by_time_ff ? spi_pkg::FieldPos : spi_pkg::FieldTime;
      end else begin
         tgt = 3'(fld_ff) + 3'd1;
      end
      dx      = 33'(x1_ff[tgt]) - 33'(x0_ff[tgt]);
      dk      = 33'(key) - 33'(x0_ff[kfld]);
      dn      = 33'(x1_ff[kfld]) - 33'(x0_ff[kfld]);
      den_pos = !dn[32] && (dn != '0);
      // A bracket that does not rise (unsorted positions) leaves the lower point.
      if (!den_pos) begin
         interp = x0_ff[tgt];
      end else if (dx[32]) begin
         interp = x0_ff[tgt] - $signed(md_quo);
      end else begin
         interp = x0_ff[tgt] + $signed(md_quo);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spi_pkg::SEQ_IDLE:    if (start) state_in = spi_pkg::SEQ_DECODE;
         spi_pkg::SEQ_DECODE:  state_in = eval_go ? spi_pkg::SEQ_SEARCH
                                                  : spi_pkg::SEQ_RESPOND;
         spi_pkg::SEQ_SEARCH:  state_in = (span_ff == '0) ? spi_pkg::SEQ_FOUND
                                                          : spi_pkg::SEQ_COMPARE;
         spi_pkg::SEQ_COMPARE: state_in = spi_pkg::SEQ_SEARCH;
         spi_pkg::SEQ_FOUND:   state_in = at_edge ? spi_pkg::SEQ_POINT
                                                  : spi_pkg::SEQ_LOAD0;
         spi_pkg::SEQ_POINT:   state_in = spi_pkg::SEQ_RESPOND;
         spi_pkg::SEQ_LOAD0:   state_in = spi_pkg::SEQ_LOAD1;
         spi_pkg::SEQ_LOAD1:   state_in = spi_pkg::SEQ_MSTART;
         spi_pkg::SEQ_MSTART:  state_in = spi_pkg::SEQ_MWAIT;
         spi_pkg::SEQ_MWAIT: begin
            if (md_done) begin
               state_in = (fld_ff == 2'd3) ? spi_pkg::SEQ_RESPOND : spi_pkg::SEQ_MSTART;
            end
         end
         spi_pkg::SEQ_RESPOND: state_in = spi_pkg::SEQ_IDLE;
         default:              state_in = spi_pkg::SEQ_IDLE;
      endcase
   end

   // Datapath and store control.
   always_comb begin
      req_in        = req_ff;
      status_in     = status_ff;
      by_time_in    = by_time_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      span_in       = span_ff;
      mid_in        = mid_ff;
      fld_in        = fld_ff;
      first_time_in = first_time_ff;
      first_pos_in  = first_pos_ff;
      last_time_in  = last_time_ff;
      last_pos_in   = last_pos_ff;
      x0_in         = x0_ff;
      x1_in         = x1_ff;
      v_in          = v_ff;
      wr_en         = 1'b0;
      rd_addr       = '0;
      md_cmd.start  = 1'b0;
      md_cmd.mag    = dx[32] ? 32'(-dx) : dx[31:0];
      md_cmd.num    = dk[31:0];
      md_cmd.den    = dn[31:0];
      case (state_ff)
         spi_pkg::SEQ_IDLE: begin
            if (start) begin
               req_in     = req_data;
               by_time_in = (spi_pkg::op_type'(req_data.operation) == spi_pkg::OP_EVAL_TIME);
            end
         end
         spi_pkg::SEQ_DECODE: begin
            for (int i = 0; i < spi_pkg::FieldCount; i++) begin
               v_in[i] = '0;
            end
            status_in = spi_pkg::ST_OK;
            lo_in     = '0;
            span_in   = count_ff;
            case (op)
               spi_pkg::OP_APPEND: begin
                  v_in[spi_pkg::FieldPos]   = req_ff.position;
                  v_in[spi_pkg::FieldTime]  = req_ff.time_req;
                  v_in[spi_pkg::FieldSpeed] = req_ff.speed;
                  v_in[spi_pkg::FieldAccel] = req_ff.accel;
                  v_in[spi_pkg::FieldJerk]  = req_ff.jerk;
                  if (is_full) begin
                     status_in = spi_pkg::ST_FULL;
                  end else if (not_later) begin
                     status_in = spi_pkg::ST_NOT_LATER;
                  end else begin
                     wr_en        = 1'b1;
                     count_in     = count_ff + CntW'(1);
                     last_time_in = req_ff.time_req;
                     last_pos_in  = req_ff.position;
                     if (count_ff == '0) begin
                        first_time_in = req_ff.time_req;
                        first_pos_in  = req_ff.position;
                     end
                  end
               end
               spi_pkg::OP_EVAL_TIME, spi_pkg::OP_EVAL_POS: begin
                  if (too_few) begin
                     status_in = spi_pkg::ST_TOO_FEW;
                  end else if (out_range) begin
                     status_in = spi_pkg::ST_OUT_RANGE;
                  end
               end
               default: begin
               end
            endcase
         end
         spi_pkg::SEQ_SEARCH: begin
            if (span_ff != '0) begin
               mid_in  = lo_ff + half;
               rd_addr = mid_in[IdxW-1:0];
            end
         end
         spi_pkg::SEQ_COMPARE: begin
            if (key_rd < key) begin
               lo_in   = mid_ff + CntW'(1);
               span_in = span_ff - half - CntW'(1);
            end else begin
               span_in = half;
            end
         end
         spi_pkg::SEQ_FOUND: begin
            if (lo_ff >= count_ff) begin
               rd_addr = IdxW'(count_ff - CntW'(1));
            end else if (lo_ff == '0) begin
               rd_addr = '0;
            end else begin
               rd_addr = IdxW'(lo_ff - CntW'(1));
            end
         end
         spi_pkg::SEQ_POINT: begin
            for (int i = 0; i < spi_pkg::FieldCount; i++) begin
               v_in[i] = rd_word[i];
            end
         end
         spi_pkg::SEQ_LOAD0: begin
            for (int i = 0; i < spi_pkg::FieldCount; i++) begin
               x0_in[i] = rd_word[i];
            end
            rd_addr = lo_ff[IdxW-1:0];
         end
         spi_pkg::SEQ_LOAD1: begin
            for (int i = 0; i < spi_pkg::FieldCount; i++) begin
               x1_in[i] = rd_word[i];
            end
            v_in[kfld] = key;
            fld_in     = 2'd0;
         end
         spi_pkg::SEQ_MSTART: begin
            md_cmd.start = 1'b1;
         end
         spi_pkg::SEQ_MWAIT: begin
            if (md_done) begin
               v_in[tgt] = interp;
               fld_in    = fld_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spi_pkg::SEQ_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff        <= req_in;
      status_ff     <= status_in;
      by_time_ff    <= by_time_in;
      lo_ff         <= lo_in;
      span_ff       <= span_in;
      mid_ff        <= mid_in;
      fld_ff        <= fld_in;
      first_time_ff <= first_time_in;
      first_pos_ff  <= first_pos_in;
      last_time_ff  <= last_time_in;
      last_pos_ff   <= last_pos_in;
      x0_ff         <= x0_in;
      x1_ff         <= x1_in;
      v_ff          <= v_in;
   end

   // The result is held in registers and shown for the one respond cycle.
   assign busy       = (state_ff != spi_pkg::SEQ_IDLE);
   assign rsp_strobe = (state_ff == spi_pkg::SEQ_RESPOND);

   always_comb begin
      rsp_data.status       = status_ff;
      rsp_data.out_position = v_ff[spi_pkg::FieldPos];
      rsp_data.out_time     = v_ff[spi_pkg::FieldTime];
      rsp_data.out_speed    = v_ff[spi_pkg::FieldSpeed];
      rsp_data.out_accel    = v_ff[spi_pkg::FieldAccel];
      rsp_data.out_jerk     = v_ff[spi_pkg::FieldJerk];
      if (count_ff != '0) begin
         rsp_data.total_duration = last_time_ff - first_time_ff;
         rsp_data.total_distance = last_pos_ff - first_pos_ff;
      end else begin
         rsp_data.total_duration = '0;
         rsp_data.total_distance = '0;
      end
      rsp_data.point_count = 9'(count_ff);
   end

endmodule

FILE: hw/rtl/spi_ram.sv
// Generic simple dual-port RAM with registered read.
module spi_ram #(
   parameter int unsigned WIDTH = spi_pkg::DataW,
   parameter int unsigned DEPTH = spi_pkg::MaxPointsDefault
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/spi_muldiv.sv
// Shared unit: one 32x32 multiply followed by a bit-serial restoring divide.
module spi_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  spi_pkg::md_cmd_type cmd,
   output logic               done,
   output logic [31:0]        quotient
);

   spi_pkg::md_state_type state_ff, state_in;
   logic [31:0] mag_ff, mag_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [31:0] quo_ff, quo_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] product;
   logic [32:0] trial;

   assign product = {32'd0, mag_ff} * {32'd0, num_ff};
   assign trial   = {rem_ff, dvd_ff[63]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spi_pkg::MD_IDLE: if (cmd.start) state_in = spi_pkg::MD_MUL;
         spi_pkg::MD_MUL:  state_in = spi_pkg::MD_DIV;
         spi_pkg::MD_DIV:  if (cnt_ff == 7'd1) state_in = spi_pkg::MD_DONE;
         spi_pkg::MD_DONE: state_in = spi_pkg::MD_IDLE;
         default:          state_in = spi_pkg::MD_IDLE;
      endcase
   end

   always_comb begin
      mag_in = mag_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         spi_pkg::MD_IDLE: begin
            mag_in = cmd.mag;
            num_in = cmd.num;
            den_in = cmd.den;
         end
         spi_pkg::MD_MUL: begin
            // When the high half is already below the divisor the quotient fits
            // in 32 bits, so only the low half needs dividing.
            if (product[63:32] < den_ff) begin
               rem_in = product[63:32];
               dvd_in = {product[31:0], 32'd0};
               cnt_in = 7'd32;
            end else begin
               rem_in = 32'd0;
               dvd_in = product;
               cnt_in = 7'd64;
            end
            quo_in = 32'd0;
         end
         spi_pkg::MD_DIV: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 32'(trial - {1'b0, den_ff});
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dvd_in = {dvd_ff[62:0], 1'b0};
            cnt_in = cnt_ff - 7'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spi_pkg::MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = (state_ff == spi_pkg::MD_DONE);
   assign quotient = quo_ff;

endmodule
